// ===== hdl/cpve_pkg.sv =====
// ----------------------------------------------------------------------------
// cpve_pkg
// Types and constants shared by the place-value numeral encoder modules.
// ----------------------------------------------------------------------------
package cpve_pkg;

  localparam int unsigned VALUE_W  = 61;
  localparam int unsigned SYM_W    = 6;
  // decimal digits needed for a 61-bit magnitude
  localparam int unsigned NUM_BCD  = 19;
  localparam int unsigned BCD_IDX_W = $clog2(NUM_BCD);
  localparam int unsigned CONV_CNT_W = $clog2(VALUE_W + 1);
  localparam int unsigned FIFO_DEPTH = 2;

  // symbol codes
  localparam logic [SYM_W-1:0] SYM_ZERO    = 6'd0;
  localparam logic [SYM_W-1:0] SYM_LIANG   = 6'd10;
  localparam logic [SYM_W-1:0] SYM_LOW_UNIT = 6'd10;
  localparam logic [SYM_W-1:0] SYM_WAN     = 6'd14;
  localparam logic [SYM_W-1:0] SYM_UP_DIGIT = 6'd16;
  localparam logic [SYM_W-1:0] SYM_UP_UNIT = 6'd25;
  localparam logic [SYM_W-1:0] SYM_MINUS   = 6'd29;
  localparam logic [SYM_W-1:0] SYM_YUAN    = 6'd30;
  localparam logic [SYM_W-1:0] SYM_JIAO    = 6'd31;
  localparam logic [SYM_W-1:0] SYM_FEN     = 6'd32;
  localparam logic [SYM_W-1:0] SYM_WHOLE   = 6'd33;
  localparam logic [SYM_W-1:0] SYM_RANGE   = 6'd34;

  typedef logic [3:0] bcd_digit_t;

  typedef struct packed {
    logic               mode;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } out_item_t;

  // one classified value, passed from front to back
  typedef struct packed {
    logic                           mode;
    logic                           neg;
    logic                           oor;
    bcd_digit_t [NUM_BCD-1:0]       digits;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RANGE,
    B_SIGN,
    B_NUM,
    B_NUMEND,
    B_YUAN,
    B_C1,
    B_C2,
    B_C3,
    B_C4,
    B_FLUSH
  } back_state_e;

  typedef enum logic [1:0] {
    PH_BIG,
    PH_ZERO,
    PH_DIG,
    PH_UNIT
  } phase_e;

endpackage

// ===== hdl/chinese_place_value_numeral_encoder.sv =====
// ----------------------------------------------------------------------------
// chinese_place_value_numeral_encoder
// Reads a signed value as a Chinese place-value numeral symbol stream.
// ----------------------------------------------------------------------------
// One value at a time: the front loads each value, converts it bit-serially
// from binary to decimal and hands it off, while the back steps through up
// to four digit phases per digit position and reads the value out at most
// one symbol per cycle, fewer while the output stalls. A two-entry queue lets
// the front convert the next value while the back still reads the current one.
module chinese_place_value_numeral_encoder #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cpve_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cpve_pkg::out_item_t out_data_o
);
  import cpve_pkg::*;

  logic push, full, pop, job_valid;
  job_t job_in, job_out;

  cpve_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .push_o(push), .full_i(full), .job_o(job_in)
  );

  cpve_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(job_in), .full_o(full),
    .pop_i(pop), .valid_o(job_valid), .data_o(job_out)
  );

  cpve_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job_out), .pop_o(pop),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push) else $error("queue overflow");

  a_range_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.symbol == SYM_RANGE) |-> out_data_o.last)
    else $error("range code not final");

  a_whole_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.symbol == SYM_WHOLE) |-> out_data_o.last)
    else $error("whole mark not final");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> job_valid) else $error("pop from empty queue");

endmodule

// ===== hdl/cpve_front.sv =====
// ----------------------------------------------------------------------------
// cpve_front
// Accepts a value, takes its magnitude, converts it to decimal one bit per
// cycle and flags values too large to read.
// ----------------------------------------------------------------------------
module cpve_front #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cpve_pkg::in_item_t in_data_i,
  output logic               push_o,
  input  logic               full_i,
  output cpve_pkg::job_t     job_o
);
  import cpve_pkg::*;

  front_state_e              state_q, state_d;
  logic [CONV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [VALUE_W-1:0]        mag_q, mag_d;
  bcd_digit_t [NUM_BCD-1:0]  bcd_q, bcd_d, bcd_adj;
  logic [4*NUM_BCD-1:0]      bcd_flat;
  logic                      mode_q, neg_q;
  logic                      oor;

  assign in_ready_o = (state_q == F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;

  always_comb begin
    for (int k = 0; k < NUM_BCD; k++) begin
      bcd_adj[k] = (bcd_q[k] >= 4'd5) ? bcd_q[k] + 4'd3 : bcd_q[k];
    end
  end

  assign bcd_flat = bcd_adj;

  // digits above the readable span make the value out of range
  always_comb begin
    oor = 1'b0;
    for (int k = 0; k < NUM_BCD; k++) begin
      if (mode_q ? (k >= MAX_DIGITS + 2) : (k >= MAX_DIGITS)) begin
        oor = oor | (bcd_q[k] != 4'd0);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (in_valid_i) state_d = F_CONV;
      F_CONV:  if (cnt_q == CONV_CNT_W'(VALUE_W - 1)) state_d = F_PUSH;
      F_PUSH:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    mag_d = mag_q;
    bcd_d = bcd_q;
    case (state_q)
      F_IDLE: begin
        cnt_d = '0;
        bcd_d = '0;
        mag_d = in_data_i.value[VALUE_W-1] ? (~in_data_i.value + 1'b1) : in_data_i.value;
      end
      F_CONV: begin
        cnt_d = cnt_q + 1'b1;
        bcd_d = {bcd_flat[4*NUM_BCD-2:0], mag_q[VALUE_W-1]};
        mag_d = {mag_q[VALUE_W-2:0], 1'b0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    if (in_valid_i && in_ready_o) begin
      mode_q <= in_data_i.mode;
      neg_q  <= in_data_i.value[VALUE_W-1];
    end
  end

  assign job_o.mode   = mode_q;
  assign job_o.neg    = neg_q;
  assign job_o.oor    = oor;
  assign job_o.digits = bcd_q;

endmodule

// ===== hdl/cpve_fifo.sv =====
// ----------------------------------------------------------------------------
// cpve_fifo
// Two-entry queue of classified values between front and back.
// ----------------------------------------------------------------------------
module cpve_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cpve_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output cpve_pkg::job_t data_o
);
  import cpve_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  job_t                    mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]        wptr_q, rptr_q;
  logic [PTR_W:0]          count_q;

  assign full_o  = (count_q == (PTR_W+1)'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      count_q <= count_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

// ===== hdl/cpve_back.sv =====
// ----------------------------------------------------------------------------
// cpve_back
// Walks the decimal digits of one value from the top and emits the numeral
// symbols one at a time; a hold stage lets the final symbol carry last.
// ----------------------------------------------------------------------------
module cpve_back #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  cpve_pkg::job_t      job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cpve_pkg::out_item_t out_data_o
);
  import cpve_pkg::*;

  localparam int unsigned POS_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  back_state_e       state_q, state_d;
  phase_e            ph_q, ph_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  job_t              job_q;
  logic              any_q, zd_q, gu_q;
  logic              hold_v_q;
  logic [SYM_W-1:0]  hold_sym_q;
  logic              out_v_q, out_last_q;
  logic [SYM_W-1:0]  out_sym_q;

  logic              out_free, step_en;
  logic              emit, set_any, set_zd, clr_zd, clr_gu, pos_done;
  logic [SYM_W-1:0]  sym;
  logic [BCD_IDX_W-1:0] idx;
  bcd_digit_t        d, jiao, fen;
  logic [1:0]        u;
  logic              liang;

  assign out_free = !out_v_q || out_ready_i;
  assign step_en  = (state_q != B_IDLE) && (state_q != B_FLUSH) && (!hold_v_q || out_free);
  assign pop_o    = (state_q == B_IDLE) && job_valid_i;

  // currency reads the yuan digits, two places above the cents
  assign idx  = BCD_IDX_W'(pos_q) + (job_q.mode ? BCD_IDX_W'(2) : BCD_IDX_W'(0));
  assign d    = job_q.digits[idx];
  assign jiao = job_q.digits[1];
  assign fen  = job_q.digits[0];
  assign u    = pos_q[1:0];
  assign liang = !job_q.mode && (d == 4'd2) && !any_q &&
                 ((u == 2'd2) || (u == 2'd3) || ((u == 2'd0) && ((pos_q >> 2) != '0)));

  // symbol decode
  always_comb begin
    emit     = 1'b0;
    sym      = SYM_ZERO;
    set_any  = 1'b0;
    set_zd   = 1'b0;
    clr_zd   = 1'b0;
    clr_gu   = 1'b0;
    pos_done = 1'b0;
    case (state_q)
      B_RANGE: begin
        emit = 1'b1;
        sym  = SYM_RANGE;
      end
      B_SIGN: begin
        emit = job_q.neg;
        sym  = SYM_MINUS;
      end
      B_NUM: begin
        case (ph_q)
          PH_BIG: begin
            // leaving a used group: its big unit
            if ((u == 2'd3) && (pos_q != POS_W'(MAX_DIGITS - 1)) && gu_q) begin
              emit   = 1'b1;
              sym    = SYM_WAN + SYM_W'(pos_q >> 2);
              clr_gu = 1'b1;
            end
          end
          PH_ZERO: begin
            if (d == 4'd0) begin
              set_zd   = any_q;
              pos_done = 1'b1;
            end else if (zd_q) begin
              emit   = 1'b1;
              sym    = SYM_ZERO;
              clr_zd = 1'b1;
            end
          end
          PH_DIG: begin
            emit    = 1'b1;
            set_any = 1'b1;
            if ((u == 2'd1) && (d == 4'd1) && !any_q) begin
              sym      = job_q.mode ? SYM_UP_UNIT + 6'd1 : SYM_LOW_UNIT + 6'd1;
              pos_done = 1'b1;
            end else begin
              if (liang) sym = SYM_LIANG;
              else if (job_q.mode) sym = SYM_UP_DIGIT + SYM_W'(d);
              else sym = SYM_W'(d);
              pos_done = (u == 2'd0);
            end
          end
          PH_UNIT: begin
            emit     = 1'b1;
            sym      = job_q.mode ? SYM_UP_UNIT + SYM_W'(u) : SYM_LOW_UNIT + SYM_W'(u);
            pos_done = 1'b1;
          end
          default: begin
          end
        endcase
      end
      B_NUMEND: begin
        emit = !any_q;
        sym  = SYM_ZERO;
      end
      B_YUAN: begin
        emit = 1'b1;
        sym  = SYM_YUAN;
      end
      B_C1: begin
        emit = 1'b1;
        if (jiao == 4'd0 && fen == 4'd0) sym = SYM_WHOLE;
        else if (jiao == 4'd0) sym = SYM_ZERO;
        else sym = SYM_UP_DIGIT + SYM_W'(jiao);
      end
      B_C2: begin
        emit = (jiao != 4'd0);
        sym  = SYM_JIAO;
      end
      B_C3: begin
        emit = (fen != 4'd0);
        sym  = SYM_UP_DIGIT + SYM_W'(fen);
      end
      B_C4: begin
        emit = (fen != 4'd0);
        sym  = SYM_FEN;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    pos_d   = pos_q;
    case (state_q)
      B_IDLE: begin
        if (job_valid_i) state_d = job_i.oor ? B_RANGE : B_SIGN;
      end
      B_FLUSH: begin
        if (out_free) state_d = B_IDLE;
      end
      default: begin
        if (step_en) begin
          case (state_q)
            B_RANGE: state_d = B_FLUSH;
            B_SIGN: begin
              state_d = B_NUM;
              ph_d    = PH_BIG;
              pos_d   = POS_W'(MAX_DIGITS - 1);
            end
            B_NUM: begin
              if (pos_done) begin
                ph_d = PH_BIG;
                if (pos_q == '0) state_d = B_NUMEND;
                else pos_d = pos_q - 1'b1;
              end else begin
                case (ph_q)
                  PH_BIG:  ph_d = PH_ZERO;
                  PH_ZERO: ph_d = PH_DIG;
                  PH_DIG:  ph_d = PH_UNIT;
                  default: ph_d = PH_BIG;
                endcase
              end
            end
            B_NUMEND: state_d = job_q.mode ? B_YUAN : B_FLUSH;
            B_YUAN:   state_d = B_C1;
            B_C1:     state_d = (jiao == 4'd0 && fen == 4'd0) ? B_FLUSH : B_C2;
            B_C2:     state_d = B_C3;
            B_C3:     state_d = B_C4;
            B_C4:     state_d = B_FLUSH;
            default:  state_d = B_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      ph_q     <= PH_BIG;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      if (state_q == B_FLUSH && out_free) begin
        out_v_q  <= 1'b1;
        hold_v_q <= 1'b0;
      end else if (step_en && emit) begin
        hold_v_q <= 1'b1;
        out_v_q  <= hold_v_q || (out_v_q && !out_ready_i);
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (pop_o) begin
      job_q <= job_i;
      any_q <= 1'b0;
      zd_q  <= 1'b0;
      gu_q  <= 1'b0;
    end else if (step_en) begin
      if (set_any) begin
        any_q <= 1'b1;
        gu_q  <= 1'b1;
      end else if (clr_gu) begin
        gu_q <= 1'b0;
      end
      if (set_zd) zd_q <= 1'b1;
      else if (clr_zd) zd_q <= 1'b0;
    end
    if (state_q == B_FLUSH && out_free) begin
      out_sym_q  <= hold_sym_q;
      out_last_q <= 1'b1;
    end else if (step_en && emit) begin
      hold_sym_q <= sym;
      if (hold_v_q) begin
        out_sym_q  <= hold_sym_q;
        out_last_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_v_q;
  assign out_data_o.symbol = out_sym_q;
  assign out_data_o.last   = out_last_q;

endmodule
